[sv/h74bc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h74bc_pkg
// Shared widths, mode codes and Hamming(7,4) encode/decode functions.
// ----------------------------------------------------------------------------
package h74bc_pkg;

    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;
    localparam int CW_W   = 7;
    localparam int SYN_W  = 3;

    // Mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Parity coverage over positions 1..7 (position p at bit p-1)
    localparam logic [CW_W-1:0] MASK_P1 = 7'h55;
    localparam logic [CW_W-1:0] MASK_P2 = 7'h66;
    localparam logic [CW_W-1:0] MASK_P4 = 7'h78;

    // One result item headed for the output register
    typedef struct packed {
        logic              load;
        logic [BYTE_W-1:0] value;
        logic              last;
    } res_t;

    function automatic logic [CW_W-1:0] encode_nibble(input logic [NIB_W-1:0] d);
        logic [CW_W-1:0] cw;
        cw    = '0;
        cw[2] = d[0];
        cw[4] = d[1];
        cw[5] = d[2];
        cw[6] = d[3];
        cw[0] = ^(cw & MASK_P1);
        cw[1] = ^(cw & MASK_P2);
        cw[3] = ^(cw & MASK_P4);
        return cw;
    endfunction

    function automatic logic [NIB_W-1:0] decode_codeword(input logic [CW_W-1:0] cw_in);
        logic [CW_W-1:0]  cw;
        logic [SYN_W-1:0] syn;
        cw  = cw_in;
        syn = {^(cw & MASK_P4), ^(cw & MASK_P2), ^(cw & MASK_P1)};
        // flip the position named by a nonzero syndrome
        if (syn != '0)
        begin
            cw = cw ^ (CW_W'(1) << (syn - SYN_W'(1)));
        end
        return {cw[6], cw[5], cw[4], cw[2]};
    endfunction

endpackage

[sv/h74bc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h74bc_in_if
// Input request channel: data byte or codeword plus end-of-stream mark.
// ----------------------------------------------------------------------------
interface h74bc_in_if
    import h74bc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              stream_last;

    modport source (output valid, output in_byte, output stream_last, input ready);
    modport sink   (input valid, input in_byte, input stream_last, output ready);
endinterface

[sv/h74bc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h74bc_out_if
// Result request channel: codeword or decoded byte plus last-of-run mark.
// ----------------------------------------------------------------------------
interface h74bc_out_if
    import h74bc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_value;
    logic              run_last;

    modport source (output valid, output out_value, output run_last, input ready);
    modport sink   (input valid, input out_value, input run_last, output ready);
endinterface

[sv/hamming74_byte_codec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming74_byte_codec
// Hamming(7,4) byte codec; mode register selects encode or decode.
// ----------------------------------------------------------------------------
// A request is registered on acceptance, and the next one can be taken as it
// completes. Encode sends two codewords per byte via the one output register;
// decode gives one byte per codeword pair, or per lone final codeword.
// Reset clears mode to encode, the pending half-pair and all valid flags.
// ----------------------------------------------------------------------------
module hamming74_byte_codec
    import h74bc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    h74bc_in_if.sink    in_ch,
    h74bc_out_if.source out_ch
);

    logic              mode_reg;
    logic [NIB_W-1:0]  held_reg;
    logic [NIB_W-1:0]  held_next;
    logic              have_half_reg;
    logic              have_half_next;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              phase_reg;
    logic              phase_next;

    logic [NIB_W-1:0]  nib_dec;
    logic [NIB_W-1:0]  nib_enc;
    logic              has_res;
    logic              is_final;
    logic              step_go;
    logic              in_done;
    logic              in_take;
    logic              can_load;
    res_t              res;

    assign nib_dec = decode_codeword(byte_reg[CW_W-1:0]);
    assign nib_enc = phase_reg ? byte_reg[BYTE_W-1:NIB_W] : byte_reg[NIB_W-1:0];

    always_comb
    begin
        has_res   = 1'b0;
        is_final  = 1'b1;
        res.value = '0;
        res.last  = 1'b1;
        case (mode_reg)
            MODE_ENCODE:
            begin
                has_res   = 1'b1;
                is_final  = phase_reg;
                res.value = {1'b0, encode_nibble(nib_enc)};
                res.last  = phase_reg;
            end
            MODE_DECODE:
            begin
                if (have_half_reg)
                begin
                    has_res   = 1'b1;
                    res.value = {nib_dec, held_reg};
                end
                else if (last_reg)
                begin
                    has_res   = 1'b1;
                    res.value = {{(BYTE_W-NIB_W){1'b0}}, nib_dec};
                end
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
        res.load = in_valid_reg && has_res;
    end

    // advance when the result fits, or at once when there is none
    assign step_go = in_valid_reg && (!has_res || can_load);
    assign in_done = step_go && is_final;

    assign in_ch.ready = !in_valid_reg || in_done;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_done)
        begin
            in_valid_next = 1'b0;
        end

        phase_next = phase_reg;
        if (in_done)
        begin
            phase_next = 1'b0;
        end
        else if (step_go)
        begin
            phase_next = 1'b1;
        end

        held_next      = held_reg;
        have_half_next = have_half_reg;
        if (cfg_we)
        begin
            // drop any pending codeword on a mode write
            held_next      = '0;
            have_half_next = 1'b0;
        end
        else if (step_go && (mode_reg == MODE_DECODE))
        begin
            if (have_half_reg)
            begin
                held_next      = '0;
                have_half_next = 1'b0;
            end
            else if (!last_reg)
            begin
                held_next      = nib_dec;
                have_half_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ENCODE;
            held_reg      <= '0;
            have_half_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            held_reg      <= held_next;
            have_half_reg <= have_half_next;
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= in_ch.in_byte;
            last_reg <= in_ch.stream_last;
        end
    end

    h74bc_result_reg u_result_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

[sv/h74bc_result_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h74bc_result_reg
// Output register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module h74bc_result_reg
    import h74bc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  res_t         res,
    output logic         can_load,
    h74bc_out_if.source  out_ch
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] value_reg;
    logic              last_reg;

    assign can_load = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.load && can_load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load && can_load)
        begin
            value_reg <= res.value;
            last_reg  <= res.last;
        end
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.out_value = value_reg;
    assign out_ch.run_last  = last_reg;

endmodule

[verif/hamming74_byte_codec_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming74_byte_codec_tb
// Drives data bytes and codewords through the codec in both modes with random
// gaps on the request side and random stalls on the result side. Checks each
// codeword and decoded byte in order against a cycle-free Hamming(7,4) model.
// ----------------------------------------------------------------------------
module hamming74_byte_codec_tb;
    import h74bc_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_PER_RUN = 150;

    typedef struct {
        logic [BYTE_W-1:0] in_byte;
        logic              stream_last;
    } codec_req_t;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } codec_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic cfg_wdata;

    h74bc_in_if  in_ch();
    h74bc_out_if out_ch();

    hamming74_byte_codec DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #10 clk = ~clk;

    // Model state
    logic             codec_mode;
    logic [NIB_W-1:0] held_nib;
    logic             half_pending;

    codec_req_t  requests[$];
    codec_word_t expected_words[$];

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches     = 0;
    int unsigned words_checked  = 0;
    int unsigned bytes_encoded  = 0;
    int unsigned cw_decoded     = 0;
    int unsigned cycle_count    = 0;

    logic        hold_arm = 1'b0;
    logic        hold_rx;
    int unsigned hold_count;

    function automatic logic [CW_W-1:0] build_codeword(input logic [NIB_W-1:0] d);
        logic p1, p2, p4;
        p1 = d[0] ^ d[1] ^ d[3];
        p2 = d[0] ^ d[2] ^ d[3];
        p4 = d[1] ^ d[2] ^ d[3];
        return {d[3], d[2], d[1], p4, d[0], p2, p1};
    endfunction

    function automatic logic [NIB_W-1:0] correct_codeword(input logic [BYTE_W-1:0] raw);
        logic [CW_W-1:0]  c;
        logic [SYN_W-1:0] s;
        c = raw[CW_W-1:0];
        s[0] = c[0] ^ c[2] ^ c[4] ^ c[6];
        s[1] = c[1] ^ c[2] ^ c[5] ^ c[6];
        s[2] = c[3] ^ c[4] ^ c[5] ^ c[6];
        if (s != 0)
        begin
            c[s - SYN_W'(1)] = ~c[s - SYN_W'(1)];
        end
        return {c[6], c[5], c[4], c[2]};
    endfunction

    task automatic predict_request(input logic [BYTE_W-1:0] b, input logic sl);
        logic [NIB_W-1:0] nib;
        if (codec_mode == MODE_ENCODE)
        begin
            expected_words.push_back('{{1'b0, build_codeword(b[3:0])}, 1'b0});
            expected_words.push_back('{{1'b0, build_codeword(b[7:4])}, 1'b1});
            bytes_encoded++;
        end
        else
        begin
            nib = correct_codeword(b);
            cw_decoded++;
            if (half_pending)
            begin
                expected_words.push_back('{{nib, held_nib}, 1'b1});
                half_pending = 1'b0;
                held_nib     = '0;
            end
            else if (sl)
            begin
                expected_words.push_back('{{4'h0, nib}, 1'b1});
            end
            else
            begin
                held_nib     = nib;
                half_pending = 1'b1;
            end
        end
    endtask

    task automatic log_error(input string what);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("ERROR @%0t: %s", $realtime, what);
        end
    endtask

    // Request driver
    always @(posedge clk)
    begin : drive_requests
        logic nxt_valid;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_request(in_ch.in_byte, in_ch.stream_last);
                void'(requests.pop_front());
            end
            // hold an offered request until it is taken
            if (in_ch.valid && !in_ch.ready)
            begin
                nxt_valid = 1'b1;
            end
            else
            begin
                nxt_valid = (requests.size() != 0) && ($urandom_range(99) >= send_gap_pct);
            end
            in_ch.valid <= nxt_valid;
            if (nxt_valid)
            begin
                in_ch.in_byte     <= requests[0].in_byte;
                in_ch.stream_last <= requests[0].stream_last;
            end
        end
    end

    // Long receiver hold-off, armed once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_rx    <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_arm && hold_count < HOLD_CYCLES)
        begin
            hold_rx    <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            hold_rx <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin : check_results
        codec_word_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                words_checked++;
                if (expected_words.size() == 0)
                begin
                    log_error($sformatf("unexpected result value=%02h last=%0b",
                                        out_ch.out_value, out_ch.run_last));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_ch.out_value !== want.value || out_ch.run_last !== want.last)
                    begin
                        log_error($sformatf("value exp=%02h got=%02h, last exp=%0b got=%0b",
                                            want.value, out_ch.out_value,
                                            want.last, out_ch.run_last));
                    end
                end
            end
            out_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("hamming74_byte_codec_tb failed");
            $finish;
        end
    end

    task automatic settle();
        do
            @(negedge clk);
        while (requests.size() != 0 || in_ch.valid || expected_words.size() != 0);
        // a held first codeword leaves no result to wait on
        repeat (4) @(negedge clk);
    endtask

    task automatic set_mode(input logic m);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        codec_mode   = m;
        held_nib     = '0;
        half_pending = 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_req(input logic [BYTE_W-1:0] b, input logic sl);
        requests.push_back('{b, sl});
    endtask

    task automatic queue_random_codeword();
        logic [BYTE_W-1:0] b;
        int unsigned       r, i, j;
        b = {1'b0, build_codeword(4'($urandom_range(15)))};
        r = $urandom_range(99);
        if (r < 45)
        begin
            // clean codeword
        end
        else if (r < 80)
        begin
            b[3'($urandom_range(6))] ^= 1'b1;
        end
        else if (r < 90)
        begin
            i = $urandom_range(6);
            j = (i + 1 + $urandom_range(5)) % 7;
            b[3'(i)] ^= 1'b1;
            b[3'(j)] ^= 1'b1;
        end
        else
        begin
            b[6:0] = 7'($urandom_range(127));
        end
        b[7] = 1'($urandom_range(1));
        queue_req(b, $urandom_range(7) == 0);
    endtask

    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = '0;
        in_ch.stream_last = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        codec_mode        = MODE_ENCODE;
        held_nib          = '0;
        half_pending      = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: encode extremes, stream_last ignored
        queue_req(8'h00, 1'b0);
        queue_req(8'hFF, 1'b1);
        queue_req(8'h0F, 1'b0);
        queue_req(8'hF0, 1'b1);
        queue_req(8'h5A, 1'b0);
        queue_req(8'hA5, 1'b0);
        settle();

        // Directed: decode pairs, every single-bit error, bit 7, double error
        set_mode(MODE_DECODE);
        queue_req({1'b0, build_codeword(4'h3)}, 1'b0);
        queue_req({1'b0, build_codeword(4'hC)}, 1'b0);
        for (int p = 0; p < CW_W; p++)
        begin
            queue_req({1'b0, build_codeword(4'h9) ^ (7'h01 << p)}, 1'b0);
        end
        queue_req({1'b1, build_codeword(4'h6)}, 1'b0);
        queue_req({1'b0, build_codeword(4'hA) ^ 7'h03}, 1'b0);
        queue_req(8'h00, 1'b1);
        // lone final codeword
        queue_req(8'h7F, 1'b1);
        queue_req(8'hFF, 1'b0);
        queue_req(8'h80, 1'b0);
        // leave a first half pending, then drop it with a mode write
        queue_req({1'b0, build_codeword(4'h5)}, 1'b0);
        settle();
        set_mode(MODE_DECODE);
        queue_req({1'b0, build_codeword(4'h2)}, 1'b1);
        settle();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct   = 19;
                    recv_stall_pct = 72;
                end
                1:
                begin
                    send_gap_pct   = 72;
                    recv_stall_pct = 19;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            set_mode(MODE_ENCODE);
            if (ph == 2)
            begin
                hold_arm = 1'b1;
            end
            for (int n = 0; n < RAND_PER_RUN; n++)
            begin
                queue_req(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            settle();
            set_mode(MODE_DECODE);
            for (int n = 0; n < RAND_PER_RUN; n++)
            begin
                queue_random_codeword();
            end
            settle();
        end

        repeat (8) @(negedge clk);
        $display("Covered %0d encoded bytes and %0d decoded codewords across both modes,",
                 bytes_encoded, cw_decoded);
        $display("%0d results checked, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("hamming74_byte_codec_tb passed");
        end
        else
        begin
            $display("hamming74_byte_codec_tb failed");
        end
        $finish;
    end

endmodule
